/* src/assert_macros.svh */
// Assertion macros used by the day difference controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GDD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");
`define GDD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define GDD_ASSERT(lbl, clk, rst_n, prop)
`define GDD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* src/gdd_pkg.sv */
// Types, constants and calendar helpers for the day difference block.
package gdd_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 22;
	localparam int QUO_W   = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Reciprocal of 100 scaled by 2^19; exact floor for every 14-bit year.
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int          RECIP_SH  = 19;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

	typedef enum logic [1:0] {
		RES_BAD,
		RES_SHORT,
		RES_WALK
	} res_kind_t;

	typedef struct packed {
		logic      load_in;
		logic      mul_en;
		logic      mul_end;
		logic      init_walk;
		logic      step;
		logic      load_out;
		res_kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic earlier;
		logic at_end;
		logic sat;
		logic out_free;
	} sts_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
			4'd2:                                        n = leap ? 5'd29 : 5'd28;
			default:                                     n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

/* src/gdd_in_if.sv */
// Input channel: two dates and the include-end-day flag.
interface gdd_in_if;
	logic                        valid;
	logic                        ready;
	logic [gdd_pkg::DAY_W-1:0]   start_day;
	logic [gdd_pkg::MONTH_W-1:0] start_month;
	logic [gdd_pkg::YEAR_W-1:0]  start_year;
	logic [gdd_pkg::DAY_W-1:0]   end_day;
	logic [gdd_pkg::MONTH_W-1:0] end_month;
	logic [gdd_pkg::YEAR_W-1:0]  end_year;
	logic                        count_end_day;

	modport source (output valid, start_day, start_month, start_year, end_day, end_month,
		end_year, count_end_day, input ready);
	modport sink (input valid, start_day, start_month, start_year, end_day, end_month,
		end_year, count_end_day, output ready);
endinterface

/* src/gdd_out_if.sv */
// Output channel: day count and invalid-date flag.
interface gdd_out_if;
	logic                        valid;
	logic                        ready;
	logic [gdd_pkg::COUNT_W-1:0] day_count;
	logic                        bad_date;

	modport source (output valid, day_count, bad_date, input ready);
	modport sink (input valid, day_count, bad_date, output ready);
endinterface

/* src/gdd_datapath.sv */
// Datapath: input word latch, leap-year unit, calendar walk and output register.
module gdd_datapath (
	input  logic          clk,
	input  logic          arst_n,
	gdd_in_if.sink        in_ch,
	gdd_out_if.source     out_ch,
	input  gdd_pkg::cmd_t cmd,
	output gdd_pkg::sts_t sts
);
	import gdd_pkg::*;

	logic [DAY_W-1:0]   sd_q, ed_q;
	logic [MONTH_W-1:0] sm_q, em_q;
	logic [YEAR_W-1:0]  sy_q, ey_q;
	logic               inc_q;

	logic [QUO_W-1:0]   quo_q;
	logic [DAY_W-1:0]   wd_q;
	logic [MONTH_W-1:0] wm_q;
	logic [YEAR_W-1:0]  wy_q;
	logic [1:0]         y4_q;
	logic [6:0]         y100_q;
	logic [1:0]         cent_q;
	logic [COUNT_W-1:0] step_q;

	logic               out_valid_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_bad_q;

	logic [YEAR_W-1:0]    mul_in;
	logic [YEAR_W+12:0]   product;
	logic [YEAR_W-1:0]    quo_x100;
	logic [YEAR_W-1:0]    rem_full;
	logic                 leap_walk, leap_end;
	logic [DAY_W-1:0]     len_walk, len_end;
	logic                 start_ok, end_ok;
	logic [COUNT_W:0]     count_sum;

	assign mul_in   = cmd.mul_end ? ey_q : sy_q;
	assign product  = mul_in * RECIP_100;
	// Multiply by 100 as shifts: 64 + 32 + 4.
	assign quo_x100 = YEAR_W'({quo_q, 6'd0}) + YEAR_W'({quo_q, 5'd0}) + YEAR_W'({quo_q, 2'd0});
	assign rem_full = sy_q - quo_x100;

	assign leap_walk = (y4_q == 2'd0) && ((y100_q != 7'd0) || (cent_q == 2'd0));
	assign leap_end  = (ey_q[1:0] == 2'd0) && ((ey_q != quo_x100) || (quo_q[1:0] == 2'd0));
	assign len_walk  = month_len(wm_q, leap_walk);
	assign len_end   = month_len(em_q, leap_end);
	assign start_ok  = (len_walk != '0) && (wd_q != '0) && (wd_q <= len_walk);
	assign end_ok    = (len_end != '0) && (ed_q != '0) && (ed_q <= len_end);

	assign sts.bad      = !(start_ok && end_ok);
	assign sts.earlier  = {sy_q, sm_q, sd_q} < {ey_q, em_q, ed_q};
	assign sts.at_end   = {wy_q, wm_q, wd_q} == {ey_q, em_q, ed_q};
	assign sts.sat      = step_q == COUNT_MAX;
	assign sts.out_free = !out_valid_q || out_ch.ready;

	assign count_sum = {1'b0, step_q} + {{COUNT_W{1'b0}}, inc_q};

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sd_q  <= in_ch.start_day;
			sm_q  <= in_ch.start_month;
			sy_q  <= in_ch.start_year;
			ed_q  <= in_ch.end_day;
			em_q  <= in_ch.end_month;
			ey_q  <= in_ch.end_year;
			inc_q <= in_ch.count_end_day;
		end
		if (cmd.mul_en) begin
			quo_q <= product[RECIP_SH +: QUO_W];
		end
		if (cmd.init_walk) begin
			// quo_q still holds the start year's quotient here.
			wd_q   <= sd_q;
			wm_q   <= sm_q;
			wy_q   <= sy_q;
			y4_q   <= sy_q[1:0];
			y100_q <= rem_full[6:0];
			cent_q <= quo_q[1:0];
			step_q <= '0;
		end else if (cmd.step) begin
			step_q <= step_q + 1'b1;
			if (wd_q == len_walk) begin
				wd_q <= DAY_FIRST;
				if (wm_q == MONTH_DEC) begin
					wm_q <= MONTH_JAN;
					wy_q <= wy_q + 1'b1;
					y4_q <= y4_q + 1'b1;
					if (y100_q == 7'd99) begin
						y100_q <= '0;
						cent_q <= cent_q + 1'b1;
					end else begin
						y100_q <= y100_q + 1'b1;
					end
				end else begin
					wm_q <= wm_q + 1'b1;
				end
			end else begin
				wd_q <= wd_q + 1'b1;
			end
		end
		if (cmd.load_out) begin
			unique case (cmd.kind)
				RES_BAD: begin
					out_count_q <= '0;
					out_bad_q   <= 1'b1;
				end
				RES_SHORT: begin
					out_count_q <= {{(COUNT_W-1){1'b0}}, inc_q};
					out_bad_q   <= 1'b0;
				end
				default: begin
					out_count_q <= count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
					out_bad_q   <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.day_count = out_count_q;
	assign out_ch.bad_date  = out_bad_q;

endmodule

/* src/gdd_ctrl.sv */
// Controller: sequences latch, leap setup, date check, walk and result hand-off.
`include "assert_macros.svh"
module gdd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  gdd_pkg::sts_t sts,
	output gdd_pkg::cmd_t cmd
);
	import gdd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVS,
		ST_DIVE,
		ST_CHECK,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t    state_q;
	res_kind_t kind_q;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd           = '0;
		cmd.kind      = kind_q;
		cmd.load_in   = (state_q == ST_IDLE) && in_valid;
		cmd.mul_en    = (state_q == ST_DIVS) || (state_q == ST_DIVE);
		cmd.mul_end   = state_q == ST_DIVE;
		cmd.init_walk = state_q == ST_DIVE;
		cmd.step      = (state_q == ST_WALK) && !sts.at_end && !sts.sat;
		cmd.load_out  = (state_q == ST_FINISH) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= RES_BAD;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DIVS;
				end
				ST_DIVS: state_q <= ST_DIVE;
				ST_DIVE: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (sts.bad) begin
						kind_q  <= RES_BAD;
						state_q <= ST_FINISH;
					end else if (!sts.earlier) begin
						kind_q  <= RES_SHORT;
						state_q <= ST_FINISH;
					end else begin
						kind_q  <= RES_WALK;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (sts.at_end || sts.sat) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A word is taken only after the previous result has been handed to the output register.
	`GDD_ASSERT(a_load_then_mul, clk, arst_n, cmd.load_in |=> cmd.mul_en && !cmd.mul_end)
	`GDD_ASSERT(a_walk_only_valid, clk, arst_n, cmd.step |-> (kind_q == RES_WALK))
	`GDD_ASSERT_NEVER(a_no_accept_busy, clk, arst_n, cmd.load_in && (cmd.step || cmd.load_out))
	`GDD_ASSERT(a_out_after_finish, clk, arst_n, cmd.load_out |=> in_ready)

endmodule

/* src/gregorian_day_difference_core.sv */
// Top level: Gregorian day difference between two dates by a day-by-day walk.
// The walk counts N, the days between the dates, one step per day,
// capped at 4194303; invalid or non-increasing date pairs skip the walk.
// Input words are accepted only in idle, after the previous word's walk has finished.
// A new input word is taken while the previous result waits in the output register.
// Reset (arst_n low, asynchronous) returns the controller to idle and drops out valid.
module gregorian_day_difference_core (
	input  logic      clk,
	input  logic      arst_n,
	gdd_in_if.sink    in_ch,
	gdd_out_if.source out_ch
);
	import gdd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gdd_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
